[src/pnd_pkg.sv]
package pnd_pkg;

  localparam int ChanW       = 8;
  localparam int PixW        = 3 * ChanW;
  localparam int CfgW        = 11;
  localparam int DiffW       = 8;
  localparam int InDataW     = PixW;
  localparam int OutDataW    = 2 * DiffW;
  localparam int MaxLineWDef = 1024;

  localparam logic [CfgW-1:0]  LineWidthReset = CfgW'(640);
  localparam logic [DiffW-1:0] DiffMax        = 8'hFF;

  typedef logic [PixW-1:0] pixel_t;

  typedef struct packed {
    pixel_t pix;
    pixel_t left_pix;
    logic   col_zero;
    logic   first_row;
  } pnd_item_t;

  function automatic logic [ChanW-1:0] chan_gap(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    logic [ChanW-1:0] r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

  function automatic logic [DiffW-1:0] pixel_gap(input pixel_t p, input pixel_t q);
    logic [ChanW-1:0] best;
    logic [ChanW-1:0] d;
    best = '0;
    for (int c = 0; c < 3; c++) begin
      d = chan_gap(p[c*ChanW +: ChanW], q[c*ChanW +: ChanW]);
      if (d > best) begin
        best = d;
      end
    end
    return DiffW'(best);
  endfunction

endpackage

[src/pnd_line_store.sv]
module pnd_line_store #(
  parameter int Depth = pnd_pkg::MaxLineWDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [AddrW-1:0]    addr_i,
  input  pnd_pkg::pixel_t     wdata_i,
  output pnd_pkg::pixel_t     rdata_o
);
  import pnd_pkg::*;

  pixel_t mem_q [Depth];
  pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/pnd_diff_stage.sv]
module pnd_diff_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  pnd_pkg::pnd_item_t            item_i,
  input  pnd_pkg::pixel_t               up_pix_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [pnd_pkg::DiffW-1:0]     left_o,
  output logic [pnd_pkg::DiffW-1:0]     up_o
);
  import pnd_pkg::*;

  logic             valid_q;
  logic [DiffW-1:0] left_q, left_d;
  logic [DiffW-1:0] up_q, up_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    left_d = item_i.col_zero  ? DiffMax : pixel_gap(item_i.pix, item_i.left_pix);
    up_d   = item_i.first_row ? DiffMax : pixel_gap(item_i.pix, up_pix_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      left_q <= left_d;
      up_q   <= up_d;
    end
  end

  assign valid_o = valid_q;
  assign left_o  = left_q;
  assign up_o    = up_q;

endmodule

[src/pixel_neighbor_difference.sv]
// Streams RGB pixels in raster order and returns, for every pixel, the largest
// per-channel absolute difference against its left neighbor (tdata bits 7:0) and
// against the pixel directly above (bits 15:8); the left result is 255 in column
// zero and the up result is 255 on the first row of a frame. A beat with tuser
// set starts a new frame. One pixel is accepted every cycle while the output
// is not stalled; the line store read and pixel registers feed the difference logic,
// whose result is held in the output register. The line width register may be
// changed only while the block is idle; zero acts as one and values above
// MaxLineW act as MaxLineW. Line store entries are not cleared by reset, so
// the rows above the first row of the first frame must be written before use.
module pixel_neighbor_difference #(
  parameter int MaxLineW = pnd_pkg::MaxLineWDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pnd_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pnd_pkg::InDataW-1:0]   s_axis_tdata,  // red, green, blue
  input  logic                          s_axis_tuser,  // frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pnd_pkg::OutDataW-1:0]  m_axis_tdata   // left_difference, up_difference
);
  import pnd_pkg::*;

  localparam int AddrW = $clog2(MaxLineW);
  localparam int CmpW  = (CfgW > AddrW + 1) ? CfgW : AddrW + 1;
  localparam logic [CmpW-1:0] MaxW = CmpW'(MaxLineW);

  logic [CfgW-1:0]  line_width_q;
  logic [AddrW-1:0] col_q, col_d, col_cur;
  logic             first_q, first_d, first_cur;
  logic [CmpW-1:0]  width_eff;
  logic             s_fire;
  logic             s1_valid_q;
  logic             s1_ready;
  pnd_item_t        item_q;
  pixel_t           up_pix;

  assign s_axis_tready = !s1_valid_q || s1_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (line_width_q == '0) begin
      width_eff = CmpW'(1);
    end else if (CmpW'(line_width_q) > MaxW) begin
      width_eff = MaxW;
    end else begin
      width_eff = CmpW'(line_width_q);
    end
    col_cur   = s_axis_tuser ? '0 : col_q;
    first_cur = s_axis_tuser ? 1'b1 : first_q;
    if (CmpW'(col_cur) + CmpW'(1) >= width_eff) begin
      col_d   = '0;
      first_d = 1'b0;
    end else begin
      col_d   = col_cur + AddrW'(1);
      first_d = first_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthReset;
      col_q        <= '0;
      first_q      <= 1'b1;
      s1_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      if (s_fire) begin
        col_q   <= col_d;
        first_q <= first_d;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q.pix       <= s_axis_tdata;
      item_q.left_pix  <= item_q.pix;
      item_q.col_zero  <= (col_cur == '0);
      item_q.first_row <= first_cur;
    end
  end

  pnd_line_store #(
    .Depth (MaxLineW),
    .AddrW (AddrW)
  ) u_line_store (
    .clk_i   (clk_i),
    .en_i    (s_fire),
    .addr_i  (col_cur),
    .wdata_i (s_axis_tdata),
    .rdata_o (up_pix)
  );

  pnd_diff_stage u_diff_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q),
    .ready_o  (s1_ready),
    .item_i   (item_q),
    .up_pix_i (up_pix),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .left_o   (m_axis_tdata[DiffW-1:0]),
    .up_o     (m_axis_tdata[OutDataW-1:DiffW])
  );

endmodule

[src/pnd_checker.sv]
module pnd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pnd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import pnd_pkg::*;

  // A result beat that is held back keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held result beat changed");

  // With no result pending, the pipeline always has room for a pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An accepted pixel reaches the output when m_axis_tready does not stall it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result beat missing");

  // The first pixel of a frame has no row above it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser ##1 m_axis_tready
    |=> m_axis_tdata[OutDataW-1:DiffW] == DiffMax)
    else $error("frame start up difference is not saturated");

endmodule

bind pixel_neighbor_difference pnd_checker u_pnd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
